[hw/rtl/frustum_box_cull_assert.svh]
// Assertion macros for the frustum box cull block.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef FRUSTUM_BOX_CULL_ASSERT_SVH
`define FRUSTUM_BOX_CULL_ASSERT_SVH

// Same-cycle implication check.
`define FBC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("frustum_box_cull: assertion failed");

// Next-cycle implication check.
`define FBC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("frustum_box_cull: assertion failed");

`endif

[hw/rtl/fbc_pkg.sv]
// Shared types, constants and codes for the frustum box cull block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fbc_pkg;

	localparam int ELEM_W        = 32;
	localparam int IDX_W         = 4;
	localparam int DIM           = 4;
	localparam int AXES          = 3;
	localparam int NUM_PLANES    = 6;
	localparam int PLANE_W       = 3;
	localparam int DEF_FRAC_BITS = 16;

	localparam logic [PLANE_W-1:0] PLANE_LAST = PLANE_W'(NUM_PLANES - 1);

	// Item kinds
	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_TEST  = 1'b1;

	typedef logic [ELEM_W-1:0] elem_t;
	// One matrix column, rows 0..3
	typedef logic [DIM-1:0][ELEM_W-1:0] col_t;
	// x, y, z
	typedef logic [AXES-1:0][ELEM_W-1:0] vec_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_DONE
	} fbc_state_t;

	// Sequencer controls for the matrix store and the dot unit
	typedef struct packed {
		logic load;   // copy columns 0..2 into the column shift line
		logic shift;  // advance the column shift line to the next axis
		logic fire;   // evaluate one plane this cycle
		logic neg;    // plane uses column 3 minus column k
		logic clear;  // clear the culled flag for a new box
	} fbc_ctrl_t;

endpackage

`default_nettype wire

[hw/rtl/fbc_if.sv]
// Valid/ready channel interfaces for the frustum box cull block.
// Depends on fbc_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface fbc_in_if import fbc_pkg::*;;
	logic              valid;
	logic              ready;
	logic              action;
	logic [IDX_W-1:0]  matrix_index;
	logic signed [ELEM_W-1:0] matrix_value;
	logic signed [ELEM_W-1:0] pos_x;
	logic signed [ELEM_W-1:0] pos_y;
	logic signed [ELEM_W-1:0] pos_z;
	logic signed [ELEM_W-1:0] extent_x;
	logic signed [ELEM_W-1:0] extent_y;
	logic signed [ELEM_W-1:0] extent_z;

	modport source (
		output valid, action, matrix_index, matrix_value,
		output pos_x, pos_y, pos_z, extent_x, extent_y, extent_z,
		input  ready
	);
	modport sink (
		input  valid, action, matrix_index, matrix_value,
		input  pos_x, pos_y, pos_z, extent_x, extent_y, extent_z,
		output ready
	);
endinterface

interface fbc_out_if;
	logic valid;
	logic ready;
	logic visible;

	modport source (output valid, visible, input ready);
	modport sink (input valid, visible, output ready);
endinterface

`default_nettype wire

[hw/rtl/frustum_box_cull.sv]
// Frustum box cull top level: sequencer, matrix store and shared plane unit.
// Depends on fbc_pkg, fbc_if, fbc_matrix, fbc_dot and the assertion header.
//
// A write beat (action 0) stores one Q16.16 view-projection element at index
// 4*row+col; it returns nothing. A test beat (action 1) runs in steps: the
// accept cycle loads the column shift line, the shared three-multiplier plane
// unit then evaluates left, right, bottom, top, near and far in turn, the
// drain state forms the last distance sum, and the done state loads the
// result register once it is empty or its old result is being taken. The
// input is not ready while a test is in flight; it is ready again as soon as
// the result is loaded, even if that result has not yet been taken. visible
// is 1 unless the box's positive vertex lies strictly behind some plane;
// boxes that straddle a plane report visible. The matrix is all zero after
// reset, which makes every box visible.
`timescale 1ns / 1ps
`default_nettype none

`include "frustum_box_cull_assert.svh"

module frustum_box_cull import fbc_pkg::*; #(
	parameter int FRAC_BITS = DEF_FRAC_BITS
) (
	input wire logic  clk,
	input wire logic  arst_n,
	fbc_in_if.sink    item,
	fbc_out_if.source result
);

	fbc_state_t         state_q, state_d;
	logic [PLANE_W-1:0] plane_q, plane_d;
	fbc_ctrl_t          ctrl;
	logic               wr_en;
	logic               take;
	logic               res_load;
	vec_t               pos_q, ext_q;
	col_t               col_k, col_3;
	logic               culled;
	logic               out_valid_q;
	logic               visible_q;

	assign take = item.valid && item.ready;

	// Sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			plane_q <= '0;
		end else begin
			state_q <= state_d;
			plane_q <= plane_d;
		end
	end

	// Next state and controls
	always_comb begin
		state_d    = state_q;
		plane_d    = plane_q;
		ctrl       = '0;
		wr_en      = 1'b0;
		res_load   = 1'b0;
		item.ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				item.ready = 1'b1;
				if (item.valid) begin
					if (item.action == ACT_TEST) begin
						ctrl.load  = 1'b1;
						ctrl.clear = 1'b1;
						plane_d    = '0;
						state_d    = ST_RUN;
					end else begin
						wr_en = 1'b1;
					end
				end
			end
			ST_RUN: begin
				ctrl.fire  = 1'b1;
				ctrl.neg   = plane_q[0];
				ctrl.shift = plane_q[0];
				if (plane_q == PLANE_LAST) begin
					state_d = ST_DRAIN;
				end else begin
					plane_d = plane_q + PLANE_W'(1);
				end
			end
			ST_DRAIN: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || result.ready) begin
					res_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Box beat capture
	always_ff @(posedge clk) begin
		if (take && item.action == ACT_TEST) begin
			pos_q <= {item.pos_z, item.pos_y, item.pos_x};
			ext_q <= {item.extent_z, item.extent_y, item.extent_x};
		end
	end

	fbc_matrix u_matrix (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_idx  (item.matrix_index),
		.wr_data (item.matrix_value),
		.ctrl    (ctrl),
		.col_k   (col_k),
		.col_3   (col_3)
	);

	fbc_dot #(
		.FRAC_BITS (FRAC_BITS)
	) u_dot (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.col_k  (col_k),
		.col_3  (col_3),
		.pos    (pos_q),
		.ext    (ext_q),
		.culled (culled)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			visible_q <= !culled;
		end
	end

	assign result.valid   = out_valid_q;
	assign result.visible = visible_q;

	// Checks
	`FBC_ASSERT_NXT(a_write_stays_idle, clk, arst_n, take && item.action == ACT_WRITE, state_q == ST_IDLE)
	`FBC_ASSERT_NXT(a_test_starts_run, clk, arst_n, take && item.action == ACT_TEST, state_q == ST_RUN && plane_q == '0)
	`FBC_ASSERT_NXT(a_done_loads_result, clk, arst_n, res_load, out_valid_q && state_q == ST_IDLE)
	`FBC_ASSERT_IMP(a_busy_not_ready, clk, arst_n, ctrl.fire || out_valid_q && state_q == ST_DONE, !item.ready)

endmodule

`default_nettype wire

[hw/rtl/fbc_matrix.sv]
// View matrix store with a column shift line feeding the dot unit.
// Depends on fbc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fbc_matrix import fbc_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [IDX_W-1:0] wr_idx,
	input  wire elem_t            wr_data,
	input  wire fbc_ctrl_t        ctrl,
	output col_t                  col_k,
	output col_t                  col_3
);

	logic [DIM*DIM-1:0][ELEM_W-1:0] m_q;
	col_t                           cols_q [AXES];

	// Matrix elements, index 4*row+col, zero after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_q <= '0;
		end else if (wr_en) begin
			m_q[wr_idx] <= wr_data;
		end
	end

	// Column shift line: head holds column k of the plane pair in progress
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			for (int c = 0; c < AXES; c++) begin
				for (int r = 0; r < DIM; r++) begin
					cols_q[c][r] <= m_q[r*DIM + c];
				end
			end
		end else if (ctrl.shift) begin
			for (int c = 0; c < AXES-1; c++) begin
				cols_q[c] <= cols_q[c+1];
			end
		end
	end

	assign col_k = cols_q[0];

	// Column 3 is read in place
	always_comb begin
		for (int r = 0; r < DIM; r++) begin
			col_3[r] = m_q[r*DIM + DIM - 1];
		end
	end

endmodule

`default_nettype wire

[hw/rtl/fbc_dot.sv]
// Shared plane unit: forms one plane, its positive vertex and the signed
// distance with three multipliers. Depends on fbc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fbc_dot import fbc_pkg::*; #(
	parameter int FRAC_BITS = DEF_FRAC_BITS
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire fbc_ctrl_t ctrl,
	input  wire col_t      col_k,
	input  wire col_t      col_3,
	input  wire vec_t      pos,
	input  wire vec_t      ext,
	output logic           culled
);

	// Plane terms and vertex coordinates carry one guard bit
	localparam int PW    = ELEM_W + 1;
	localparam int PRODW = 2 * PW;
	localparam int DW    = PW + FRAC_BITS;
	localparam int ACC_W = ((PRODW > DW) ? PRODW : DW) + 2;

	logic signed [PW-1:0]    t [DIM];
	logic signed [PW-1:0]    v [AXES];
	logic signed [PRODW-1:0] prod_s1 [AXES];
	logic signed [ACC_W-1:0] dterm_s1;
	logic                    vld_s1;
	logic signed [ACC_W-1:0] acc;
	logic                    culled_q;

	// Plane: column 3 plus or minus column k, then the positive vertex
	always_comb begin
		for (int r = 0; r < DIM; r++) begin
			if (ctrl.neg) begin
				t[r] = $signed({col_3[r][ELEM_W-1], col_3[r]})
				     - $signed({col_k[r][ELEM_W-1], col_k[r]});
			end else begin
				t[r] = $signed({col_3[r][ELEM_W-1], col_3[r]})
				     + $signed({col_k[r][ELEM_W-1], col_k[r]});
			end
		end
		for (int i = 0; i < AXES; i++) begin
			if (t[i] > 0) begin
				v[i] = $signed({pos[i][ELEM_W-1], pos[i]})
				     + $signed({ext[i][ELEM_W-1], ext[i]});
			end else begin
				v[i] = $signed({pos[i][ELEM_W-1], pos[i]});
			end
		end
	end

	// Multiplier stage
	always_ff @(posedge clk) begin
		for (int i = 0; i < AXES; i++) begin
			prod_s1[i] <= t[i] * v[i];
		end
		dterm_s1 <= ACC_W'(t[DIM-1]) <<< FRAC_BITS;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= ctrl.fire;
		end
	end

	// Exact distance sum, sign decides culling
	always_comb begin
		acc = dterm_s1;
		for (int i = 0; i < AXES; i++) begin
			acc = acc + ACC_W'(prod_s1[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			culled_q <= 1'b0;
		end else if (ctrl.clear) begin
			culled_q <= 1'b0;
		end else if (vld_s1 && acc[ACC_W-1]) begin
			culled_q <= 1'b1;
		end
	end

	assign culled = culled_q;

endmodule

`default_nettype wire

[dv/tb_top.sv]
// Self-checking bench for frustum_box_cull: matrix writes and box tests driven
// through the valid/ready channels, visibility predicted in-bench and compared per beat.
// Depends on fbc_pkg, fbc_if and the frustum_box_cull RTL.
`timescale 1ns / 1ps

module tb_top;
	import fbc_pkg::*;

	localparam int FRAC_BITS  = DEF_FRAC_BITS;
	localparam int ONE        = 1 << FRAC_BITS;
	localparam int RAND_ITEMS = 400;
	localparam int HOLD_LEN   = 400;
	localparam int QUIET_MAX  = 3000;
	localparam int SETTLE     = 20;
	localparam logic signed [ELEM_W-1:0] EMAX = 32'sh7FFF_FFFF;
	localparam logic signed [ELEM_W-1:0] EMIN = 32'sh8000_0000;

	typedef struct {
		logic                     act;
		logic [IDX_W-1:0]         idx;
		logic signed [ELEM_W-1:0] val, px, py, pz, ex, ey, ez;
		int                       typed;  // -1: take the prediction
	} beat_t;

	logic clk = 1'b0;
	logic arst_n;

	fbc_in_if  box_ch ();
	fbc_out_if verdict_ch ();

	frustum_box_cull u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (box_ch),
		.result (verdict_ch)
	);

	always #6 clk = ~clk;

	logic signed [ELEM_W-1:0] mat_shadow [16];
	bit    visible_q [$];
	beat_t tbl [$];
	int    typed_exp = -1;
	int    fails = 0;
	int    burst_left = 0;
	bit    hold_req = 1'b0;
	int    quiet = 0;

	task automatic note_fail(input string msg);
		fails++;
		if (fails <= 10) begin
			$display("%s", msg);
		end
	endtask

	function automatic logic signed [ELEM_W-1:0] mel(input int r, input int c);
		return mat_shadow[r * DIM + c];
	endfunction

	// Positive-vertex test against the six planes column 3 +/- column k
	function automatic bit frustum_keeps_box(input logic signed [ELEM_W-1:0] p [3],
			input logic signed [ELEM_W-1:0] e [3]);
		logic signed [127:0] dsum, n, v, dd;
		bit keep;
		keep = 1'b1;
		for (int k = 0; k < AXES; k++) begin
			for (int s = 0; s < 2; s++) begin
				dd = (s == 0) ? mel(3, 3) + mel(3, k) : mel(3, 3) - mel(3, k);
				dsum = dd <<< FRAC_BITS;
				for (int i = 0; i < AXES; i++) begin
					n = (s == 0) ? mel(i, 3) + mel(i, k) : mel(i, 3) - mel(i, k);
					v = p[i] + ((n > 0) ? e[i] : 32'sd0);
					dsum += n * v;
				end
				if (dsum < 0) begin
					keep = 1'b0;
				end
			end
		end
		return keep;
	endfunction

	function automatic beat_t mk_write(input int idx, input logic signed [ELEM_W-1:0] val);
		beat_t b;
		b = '{act: ACT_WRITE, idx: IDX_W'(idx), val: val, px: '0, py: '0, pz: '0,
			ex: '0, ey: '0, ez: '0, typed: -1};
		return b;
	endfunction

	function automatic beat_t mk_test(input logic signed [ELEM_W-1:0] px, py, pz, ex, ey, ez,
			input int typed);
		beat_t b;
		b = '{act: ACT_TEST, idx: '0, val: '0, px: px, py: py, pz: pz,
			ex: ex, ey: ey, ez: ez, typed: typed};
		return b;
	endfunction

	// Mostly small Q16.16 values, diagonal biased positive, some full-range
	function automatic logic signed [ELEM_W-1:0] rand_elem(input int idx);
		int v;
		case ($urandom_range(0, 9))
			0: v = $urandom;
			1: v = 0;
			default: begin
				v = int'($urandom_range(0, 6 * ONE)) - 3 * ONE;
				if (idx % 5 == 0) begin
					v += 2 * ONE;
				end
			end
		endcase
		return v;
	endfunction

	function automatic logic signed [ELEM_W-1:0] rand_pos();
		if ($urandom_range(0, 9) == 0) begin
			return $urandom;
		end
		return int'($urandom_range(0, 8 * ONE)) - 4 * ONE;
	endfunction

	function automatic logic signed [ELEM_W-1:0] rand_ext();
		case ($urandom_range(0, 9))
			0: return $urandom;
			1: return -int'($urandom_range(0, 2 * ONE));
			default: return int'($urandom_range(0, 3 * ONE));
		endcase
	endfunction

	task automatic idle_sender(input int cycles);
		repeat (cycles) begin
			@(negedge clk);
			box_ch.valid <= 1'b0;
		end
	endtask

	// Bursty sender: random gaps between bursts, fields the block ignores get noise
	task automatic send_beat(input beat_t b);
		if (burst_left == 0) begin
			if ($urandom_range(0, 4) == 0) begin
				burst_left = $urandom_range(20, 40);
			end else begin
				idle_sender($urandom_range(1, 8));
				burst_left = $urandom_range(1, 12);
			end
		end
		burst_left--;
		@(negedge clk);
		typed_exp = b.typed;
		box_ch.valid  <= 1'b1;
		box_ch.action <= b.act;
		if (b.act == ACT_WRITE) begin
			box_ch.matrix_index <= b.idx;
			box_ch.matrix_value <= b.val;
			box_ch.pos_x    <= $urandom;
			box_ch.pos_y    <= $urandom;
			box_ch.pos_z    <= $urandom;
			box_ch.extent_x <= $urandom;
			box_ch.extent_y <= $urandom;
			box_ch.extent_z <= $urandom;
		end else begin
			box_ch.matrix_index <= IDX_W'($urandom);
			box_ch.matrix_value <= $urandom;
			box_ch.pos_x    <= b.px;
			box_ch.pos_y    <= b.py;
			box_ch.pos_z    <= b.pz;
			box_ch.extent_x <= b.ex;
			box_ch.extent_y <= b.ey;
			box_ch.extent_z <= b.ez;
		end
		@(posedge clk);
		while (!box_ch.ready) @(posedge clk);
	endtask

	// Wait at a falling edge until every pending verdict has come back
	task automatic drain_verdicts();
		@(negedge clk);
		box_ch.valid <= 1'b0;
		while (visible_q.size() != 0) @(negedge clk);
	endtask

	// Input side: track matrix writes, predict verdicts for tests
	always @(posedge clk) begin : accept_mon
		logic signed [ELEM_W-1:0] p [3];
		logic signed [ELEM_W-1:0] e [3];
		if (arst_n && box_ch.valid && box_ch.ready) begin
			if (box_ch.action == ACT_WRITE) begin
				mat_shadow[box_ch.matrix_index] = box_ch.matrix_value;
			end else begin
				p = '{box_ch.pos_x, box_ch.pos_y, box_ch.pos_z};
				e = '{box_ch.extent_x, box_ch.extent_y, box_ch.extent_z};
				if (typed_exp >= 0) begin
					visible_q.push_back(typed_exp[0]);
				end else begin
					visible_q.push_back(frustum_keeps_box(p, e));
				end
			end
		end
	end

	// Output side: compare each verdict beat with the oldest prediction
	always @(posedge clk) begin : verdict_mon
		bit want;
		if (arst_n && verdict_ch.valid && verdict_ch.ready) begin
			if (visible_q.size() == 0) begin
				note_fail($sformatf("t=%0t: verdict %0b with nothing pending", $time,
					verdict_ch.visible));
			end else begin
				want = visible_q.pop_front();
				if (verdict_ch.visible !== want) begin
					note_fail($sformatf("t=%0t: visible exp %0b got %0b", $time, want,
						verdict_ch.visible));
				end
			end
		end
	end

	// Watchdog on cycles with no beat on either channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((box_ch.valid && box_ch.ready) || (verdict_ch.valid && verdict_ch.ready)) begin
				quiet = 0;
			end else begin
				quiet++;
				if (quiet >= QUIET_MAX) begin
					$display("RESULT: ERROR");
					$finish;
				end
			end
		end
	end

	// Receiver: stall pattern that changes mode, plus one long hold on request
	initial begin : receiver
		int mode, mode_left, phase, hold_left;
		mode_left = 0;
		phase     = 0;
		hold_left = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req && hold_left == 0) begin
				hold_left = HOLD_LEN;
			end
			if (hold_left > 0) begin
				hold_left--;
				if (hold_left == 0) begin
					hold_req = 1'b0;
				end
				verdict_ch.ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode      = $urandom_range(0, 3);
					mode_left = $urandom_range(16, 80);
				end
				mode_left--;
				phase++;
				case (mode)
					0: verdict_ch.ready <= 1'b1;
					1: verdict_ch.ready <= 1'($urandom_range(0, 1));
					2: verdict_ch.ready <= (phase % 3 == 0);
					default: verdict_ch.ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	initial begin : main_seq
		int  sent;
		int  pick;
		bit  held, drained;
		beat_t b;

		arst_n                = 1'b0;
		box_ch.valid          = 1'b0;
		box_ch.action         = ACT_WRITE;
		box_ch.matrix_index   = '0;
		box_ch.matrix_value   = '0;
		box_ch.pos_x          = '0;
		box_ch.pos_y          = '0;
		box_ch.pos_z          = '0;
		box_ch.extent_x       = '0;
		box_ch.extent_y       = '0;
		box_ch.extent_z       = '0;
		verdict_ch.ready      = 1'b0;
		for (int i = 0; i < 16; i++) begin
			mat_shadow[i] = '0;
		end
		held    = 1'b0;
		drained = 1'b0;
		sent    = 0;

		// Directed rows; zero matrix after reset keeps everything visible
		tbl.push_back(mk_test(EMAX, EMAX, EMAX, EMIN, EMIN, EMIN, 1));
		tbl.push_back(mk_test(EMIN, EMIN, EMIN, EMAX, EMAX, EMAX, 1));
		tbl.push_back(mk_test(0, 0, 0, 0, 0, 0, 1));
		// Only m33 set: all normals zero, plane reduces to the sign of d
		tbl.push_back(mk_write(15, EMIN));
		tbl.push_back(mk_test(0, 0, 0, ONE, ONE, ONE, 0));
		tbl.push_back(mk_write(15, EMAX));
		tbl.push_back(mk_test(EMIN, EMIN, EMIN, EMAX, EMAX, EMAX, 1));
		// Identity matrix: unit clip cube
		tbl.push_back(mk_write(15, ONE));
		tbl.push_back(mk_write(0, ONE));
		tbl.push_back(mk_write(5, ONE));
		tbl.push_back(mk_write(10, ONE));
		tbl.push_back(mk_test(-ONE / 2, -ONE / 2, -ONE / 2, ONE, ONE, ONE, -1));
		tbl.push_back(mk_test(5 * ONE, 0, 0, ONE, ONE, ONE, -1));
		// Negative extent puts the vertex below the corner
		tbl.push_back(mk_test(5 * ONE, 0, 0, -6 * ONE, 0, 0, -1));
		tbl.push_back(mk_test(-2 * ONE, -2 * ONE, -2 * ONE, 3 * ONE, 3 * ONE, 3 * ONE, -1));
		tbl.push_back(mk_test(EMAX, EMAX, EMAX, EMAX, EMAX, EMAX, -1));
		tbl.push_back(mk_test(EMIN, EMIN, EMIN, EMIN, EMIN, EMIN, -1));
		tbl.push_back(mk_write(3, EMAX));
		tbl.push_back(mk_write(12, EMIN));
		tbl.push_back(mk_test(0, 0, 0, ONE, ONE, ONE, -1));
		tbl.push_back(mk_write(7, -1));
		tbl.push_back(mk_test(-ONE, 2 * ONE, -3 * ONE, 0, 0, 0, -1));

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (tbl[r]) begin
			send_beat(tbl[r]);
		end

		// Random part: whole-matrix reloads, single element writes, box tests
		while (sent < RAND_ITEMS) begin
			if (!held && sent >= 120) begin
				hold_req = 1'b1;
				held     = 1'b1;
			end
			if (!drained && sent >= 260) begin
				drain_verdicts();
				drained = 1'b1;
			end
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				for (int i = 0; i < 16; i++) begin
					send_beat(mk_write(i, rand_elem(i)));
				end
				sent += 16;
			end else if (pick < 22) begin
				pick = $urandom_range(0, 15);
				send_beat(mk_write(pick, rand_elem(pick)));
				sent++;
			end else begin
				b = mk_test(rand_pos(), rand_pos(), rand_pos(), rand_ext(), rand_ext(),
					rand_ext(), -1);
				send_beat(b);
				sent++;
			end
		end

		drain_verdicts();
		repeat (SETTLE) @(posedge clk);
		if (visible_q.size() != 0) begin
			note_fail($sformatf("%0d verdicts never arrived", visible_q.size()));
		end
		if (fails == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/fbc_pkg.sv
hw/rtl/fbc_if.sv
hw/rtl/fbc_matrix.sv
hw/rtl/fbc_dot.sv
hw/rtl/frustum_box_cull.sv
dv/tb_top.sv
